// File: sv/dsmm_pkg.sv
// ============================================================================
// dsmm_pkg
// Shared defaults, fixed-point constants and control types for the dual
// stream min/max/moving-average core.
// ============================================================================
package dsmm_pkg;

    localparam int DEF_WINDOW_LEN  = 5;
    localparam int DEF_SAMPLE_BITS = 16;

    // Fractional bits of the averages.
    localparam int FRAC_BITS = 8;

    // Per-transfer control handed from the top level to each channel.
    typedef struct packed {
        logic step;   // an item moves into the result register this cycle
        logic first;  // first item since reset: seeds max and min
        logic drop;   // oldest history entry leaves the window
    } chan_ctrl_t;

endpackage

// File: sv/dsmm_mean.sv
// ============================================================================
// dsmm_mean
// Rounded mean of a window sum, scaled to 8 fractional bits, ties away from
// zero. The divide by the sample count uses a constant reciprocal table.
// ============================================================================
module dsmm_mean #(
    parameter int WINDOW_LEN  = dsmm_pkg::DEF_WINDOW_LEN,
    parameter int SAMPLE_BITS = dsmm_pkg::DEF_SAMPLE_BITS,
    localparam int SUMW = SAMPLE_BITS + $clog2(WINDOW_LEN),
    localparam int CW   = $clog2(WINDOW_LEN + 1),
    localparam int AW   = SAMPLE_BITS + dsmm_pkg::FRAC_BITS
) (
    input  logic signed [SUMW-1:0] sum,
    input  logic        [CW-1:0]   count,
    output logic signed [AW-1:0]   avg
);

    localparam int MW = SUMW + dsmm_pkg::FRAC_BITS;
    localparam int K  = MW + $clog2(WINDOW_LEN);
    localparam int RW = K + 1;
    localparam int PW = MW + RW;

    // recip_tab[n] = ceil(2^K / n); with K this large the product is exact.
    logic [RW-1:0] recip_tab [2**CW];

    for (genvar g = 0; g < 2**CW; g++) begin : g_rcp
        if (g >= 1 && g <= WINDOW_LEN) begin : g_used
            localparam logic [63:0] ONE_K = 64'd1 << K;
            localparam logic [63:0] RCP   = (ONE_K + 64'(g) - 64'd1) / 64'(g);
            assign recip_tab[g] = RCP[RW-1:0];
        end else begin : g_unused
            assign recip_tab[g] = '0;
        end
    end

    logic            neg;
    logic [SUMW-1:0] mag;
    logic [MW-1:0]   scaled;
    logic [PW-1:0]   prod;
    logic [AW-1:0]   quot;

    assign neg    = sum[SUMW-1];
    assign mag    = neg ? SUMW'(-sum) : SUMW'(sum);
    assign scaled = {mag, dsmm_pkg::FRAC_BITS'(0)} + MW'(count >> 1);
    assign prod   = PW'(scaled) * PW'(recip_tab[count]);
    assign quot   = prod[K +: AW];
    assign avg    = neg ? AW'(-quot) : AW'(quot);

endmodule

// File: sv/dsmm_channel.sv
// ============================================================================
// dsmm_channel
// One sample channel: running max and min, sample history and a running
// window sum feeding the rounded mean.
// ============================================================================
module dsmm_channel #(
    parameter int WINDOW_LEN  = dsmm_pkg::DEF_WINDOW_LEN,
    parameter int SAMPLE_BITS = dsmm_pkg::DEF_SAMPLE_BITS,
    localparam int CW = $clog2(WINDOW_LEN + 1),
    localparam int AW = SAMPLE_BITS + dsmm_pkg::FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dsmm_pkg::chan_ctrl_t          ctrl,
    input  logic        [CW-1:0]          count,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS-1:0] max_next,
    output logic signed [SAMPLE_BITS-1:0] min_next,
    output logic signed [AW-1:0]          avg_next
);

    localparam int SUMW  = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int DEPTH = WINDOW_LEN - 1;

    logic signed [SAMPLE_BITS-1:0] hist_reg [DEPTH];
    logic signed [SAMPLE_BITS-1:0] high_reg;
    logic signed [SAMPLE_BITS-1:0] low_reg;
    logic signed [SUMW-1:0]        win_sum_reg;
    logic signed [SUMW-1:0]        win_sum_next;
    logic signed [SUMW-1:0]        total;

    // win_sum_reg holds the sum of the valid history entries only.
    assign total        = win_sum_reg + SUMW'(sample);
    assign win_sum_next = ctrl.drop ? total - SUMW'(hist_reg[DEPTH-1]) : total;

    assign max_next = (ctrl.first || sample > high_reg) ? sample : high_reg;
    assign min_next = (ctrl.first || sample < low_reg)  ? sample : low_reg;

    dsmm_mean #(
        .WINDOW_LEN (WINDOW_LEN),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_mean (
        .sum  (total),
        .count(count),
        .avg  (avg_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_sum_reg <= '0;
        end else if (ctrl.step) begin
            win_sum_reg <= win_sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.step) begin
            high_reg    <= max_next;
            low_reg     <= min_next;
            hist_reg[0] <= sample;
            for (int i = 1; i < DEPTH; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

endmodule

// File: sv/dual_stream_min_max_moving_average_core.sv
// Path: a transfer accepted on s_ passes the input register and then the
// result register before it is presented on m_; the per-channel window sum,
// min/max compare and one reciprocal multiply sit between the two registers.
// Throughput: one item per cycle while m_tready does not stall the output.
// Reset: synchronous active-low aresetn clears valids, sample count and
// window sums; max and min are seeded by the first sample after reset.
// ============================================================================
// dual_stream_min_max_moving_average_core
// Running max, min and moving average for charge and temperature streams.
// ============================================================================
module dual_stream_min_max_moving_average_core #(
    parameter int WINDOW_LEN  = dsmm_pkg::DEF_WINDOW_LEN,
    parameter int SAMPLE_BITS = dsmm_pkg::DEF_SAMPLE_BITS,
    localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((6 * SAMPLE_BITS + 2 * dsmm_pkg::FRAC_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: charge_sample, temp_sample.
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // Fields from bit 0: charge_max, charge_min, charge_avg,
    // temp_max, temp_min, temp_avg.
    output logic [OUT_W-1:0] m_tdata
);

    localparam int SB = SAMPLE_BITS;
    localparam int AW = SAMPLE_BITS + dsmm_pkg::FRAC_BITS;
    localparam int CW = $clog2(WINDOW_LEN + 1);

    logic                 in_valid_reg;
    logic signed [SB-1:0] in_charge_reg;
    logic signed [SB-1:0] in_temp_reg;
    logic                 out_valid_reg;
    logic signed [SB-1:0] out_cmax_reg, out_cmin_reg, out_tmax_reg, out_tmin_reg;
    logic signed [AW-1:0] out_cavg_reg, out_tavg_reg;
    logic [CW-1:0]        seen_reg;
    logic [CW-1:0]        seen_next;
    logic [CW-1:0]        count;
    logic                 out_free;
    logic                 advance;
    dsmm_pkg::chan_ctrl_t ctrl;

    logic signed [SB-1:0] cmax_next, cmin_next, tmax_next, tmin_next;
    logic signed [AW-1:0] cavg_next, tavg_next;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign count     = (seen_reg < CW'(WINDOW_LEN)) ? seen_reg + CW'(1) : CW'(WINDOW_LEN);
    assign seen_next = (seen_reg < CW'(WINDOW_LEN)) ? seen_reg + CW'(1) : seen_reg;

    assign ctrl.step  = advance;
    assign ctrl.first = (seen_reg == '0);
    assign ctrl.drop  = (seen_reg >= CW'(WINDOW_LEN - 1));

    dsmm_channel #(
        .WINDOW_LEN (WINDOW_LEN),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_charge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .count   (count),
        .sample  (in_charge_reg),
        .max_next(cmax_next),
        .min_next(cmin_next),
        .avg_next(cavg_next)
    );

    dsmm_channel #(
        .WINDOW_LEN (WINDOW_LEN),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_temp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .count   (count),
        .sample  (in_temp_reg),
        .max_next(tmax_next),
        .min_next(tmin_next),
        .avg_next(tavg_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seen_reg      <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                seen_reg <= seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_charge_reg <= s_tdata[0 +: SB];
            in_temp_reg   <= s_tdata[SB +: SB];
        end
        if (advance) begin
            out_cmax_reg <= cmax_next;
            out_cmin_reg <= cmin_next;
            out_cavg_reg <= cavg_next;
            out_tmax_reg <= tmax_next;
            out_tmin_reg <= tmin_next;
            out_tavg_reg <= tavg_next;
        end
    end

    // The fields are zero-extended up to whole bytes.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_tavg_reg, out_tmin_reg, out_tmax_reg,
                              out_cavg_reg, out_cmin_reg, out_cmax_reg});

    // The sample count saturates at the window length.
    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= CW'(WINDOW_LEN))
        else $error("sample count beyond window length");

    // Every item that leaves the input register shows up as a result.
    a_advance_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("advanced item did not reach the result register");

    // Running extremes stay ordered on every delivered result.
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_cmax_reg >= out_cmin_reg) && (out_tmax_reg >= out_tmin_reg))
        else $error("running max below running min");

endmodule
